[rtl/fcsg_pkg.sv]
// Package for the filled circle span generator.
// Holds the shared widths, the span record type and the row limit function.
// It has no dependencies.
package fcsg_pkg;

    localparam int COORD_W        = 16;
    localparam int RAD_W          = 5;
    localparam int LEN_W          = 6;
    localparam int COLOR_W        = 16;
    localparam int SQ_W           = 11;
    localparam int DEF_MAX_RADIUS = 16;

    typedef struct packed {
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y;
        logic [LEN_W-1:0]   length;
        logic [COLOR_W-1:0] color;
    } t_span;

    // Last row offset of the inner loop: r*707/1000 + 1.
    // The factor 181/256 gives the same floor for every 5-bit radius.
    function automatic logic [RAD_W-1:0] imax_of(input logic [RAD_W-1:0] r);
        logic [12:0] prod;
        prod = 13'(r) * 13'd181;
        return RAD_W'(prod >> 8) + RAD_W'(1);
    endfunction

endpackage

[rtl/filled_circle_span_generator.sv]
// Filled circle span generator, top level; uses fcsg_pkg, fcsg_seq and fcsg_out.
// The row sequencer sets imax = r*707/1000 + 1, the last inner row offset; output stalls
// hold it. A disc of zero radius is taken but yields no spans. A new disc is taken when the
// sequencer is idle. Synchronous active-low reset idles the sequencer, empties the output.
module filled_circle_span_generator
    import fcsg_pkg::*;
#(
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_center_x,
    input  logic [COORD_W-1:0] i_center_y,
    input  logic [RAD_W-1:0]   i_radius,
    input  logic [COLOR_W-1:0] i_fill_color,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COORD_W-1:0] o_span_x_start,
    output logic [COORD_W-1:0] o_span_y,
    output logic [LEN_W-1:0]   o_span_length,
    output logic [COLOR_W-1:0] o_span_color,
    output logic               o_last_span
);

    logic  adv;
    logic  cand_valid;
    t_span cand;
    logic  done;

    fcsg_seq #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_radius     (i_radius),
        .i_fill_color (i_fill_color),
        .i_adv        (adv),
        .o_cand_valid (cand_valid),
        .o_cand       (cand),
        .o_done       (done)
    );

    fcsg_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cand_valid   (cand_valid),
        .i_cand         (cand),
        .i_done         (done),
        .o_adv          (adv),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_span_x_start (o_span_x_start),
        .o_span_y       (o_span_y),
        .o_span_length  (o_span_length),
        .o_span_color   (o_span_color),
        .o_last_span    (o_last_span)
    );

endmodule

[rtl/fcsg_sqcmp.sv]
// Shared square-sum unit of the span generator.
// Forms a*a + b*b and compares it against a limit; uses fcsg_pkg.
module fcsg_sqcmp
    import fcsg_pkg::*;
(
    input  logic [RAD_W-1:0] i_a,
    input  logic [RAD_W-1:0] i_b,
    input  logic [SQ_W-1:0]  i_lim,
    output logic [SQ_W-1:0]  o_sum,
    output logic             o_gt
);

    logic [SQ_W-1:0] sq_a;
    logic [SQ_W-1:0] sq_b;

    assign sq_a  = SQ_W'(i_a) * SQ_W'(i_a);
    assign sq_b  = SQ_W'(i_b) * SQ_W'(i_b);
    assign o_sum = sq_a + sq_b;
    assign o_gt  = (o_sum > i_lim);

endmodule

[rtl/fcsg_seq.sv]
// Sequencer of the span generator: walks the rows of one disc.
// One candidate span per span state; uses fcsg_pkg and fcsg_sqcmp.
module fcsg_seq
    import fcsg_pkg::*;
#(
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_center_x,
    input  logic [COORD_W-1:0] i_center_y,
    input  logic [RAD_W-1:0]   i_radius,
    input  logic [COLOR_W-1:0] i_fill_color,
    input  logic               i_adv,
    output logic               o_cand_valid,
    output t_span              o_cand,
    output logic               o_done
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CENTER = 3'd1;
    localparam logic [2:0] S_TEST   = 3'd2;
    localparam logic [2:0] S_OUTP   = 3'd3;
    localparam logic [2:0] S_OUTM   = 3'd4;
    localparam logic [2:0] S_INP    = 3'd5;
    localparam logic [2:0] S_INM    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]         r_state;
    logic [COORD_W-1:0] r_cx;
    logic [COORD_W-1:0] r_cy;
    logic [COLOR_W-1:0] r_col;
    logic [RAD_W-1:0]   r_r;
    logic [RAD_W-1:0]   r_x;
    logic [RAD_W-1:0]   r_i;
    logic [RAD_W-1:0]   r_imax;
    logic [SQ_W-1:0]    r_sqmax;

    logic [RAD_W-1:0]   rad_clamp;
    logic [RAD_W-1:0]   u_a;
    logic [RAD_W-1:0]   u_b;
    logic [SQ_W-1:0]    u_lim;
    logic [SQ_W-1:0]    u_sum;
    logic               u_gt;
    logic [RAD_W-1:0]   i_m1;

    assign rad_clamp = (i_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : i_radius;
    assign o_ready   = (r_state == S_IDLE);
    assign i_m1      = r_i - RAD_W'(1);

    always_comb begin
        if (r_state == S_IDLE) begin
            u_a   = rad_clamp;
            u_b   = '0;
            u_lim = '0;
        end else begin
            u_a   = r_i;
            u_b   = r_x;
            u_lim = r_sqmax;
        end
    end

    fcsg_sqcmp u_sqcmp (
        .i_a   (u_a),
        .i_b   (u_b),
        .i_lim (u_lim),
        .o_sum (u_sum),
        .o_gt  (u_gt)
    );

    always_comb begin
        o_cand_valid   = 1'b0;
        o_done         = 1'b0;
        o_cand.color   = r_col;
        o_cand.x_start = r_cx - COORD_W'(r_x);
        o_cand.y       = r_cy;
        o_cand.length  = {r_x, 1'b0};
        case (r_state)
            S_CENTER: begin
                o_cand_valid   = i_adv;
                o_cand.x_start = r_cx - COORD_W'(r_r);
                o_cand.length  = {r_r, 1'b0};
            end
            S_OUTP: begin
                o_cand_valid   = i_adv;
                o_cand.x_start = r_cx - COORD_W'(i_m1);
                o_cand.y       = r_cy + COORD_W'(r_x);
                o_cand.length  = {i_m1, 1'b0};
            end
            S_OUTM: begin
                o_cand_valid   = i_adv;
                o_cand.x_start = r_cx - COORD_W'(i_m1);
                o_cand.y       = r_cy - COORD_W'(r_x);
                o_cand.length  = {i_m1, 1'b0};
            end
            S_INP: begin
                o_cand_valid = i_adv;
                o_cand.y     = r_cy + COORD_W'(r_i);
            end
            S_INM: begin
                o_cand_valid = i_adv;
                o_cand.y     = r_cy - COORD_W'(r_i);
            end
            S_DONE: begin
                o_done = i_adv;
            end
            default: begin
                o_cand_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cx    <= i_center_x;
                        r_cy    <= i_center_y;
                        r_col   <= i_fill_color;
                        r_r     <= rad_clamp;
                        r_x     <= rad_clamp;
                        r_i     <= RAD_W'(1);
                        r_imax  <= imax_of(rad_clamp);
                        r_sqmax <= u_sum + SQ_W'(rad_clamp >> 1);
                        if (rad_clamp != '0) begin
                            r_state <= S_CENTER;
                        end
                    end
                end
                S_CENTER: begin
                    if (i_adv) begin
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (u_gt && (r_x > r_imax)) begin
                        r_state <= S_OUTP;
                    end else begin
                        if (u_gt && (r_x != '0)) begin
                            r_x <= r_x - RAD_W'(1);
                        end
                        r_state <= S_INP;
                    end
                end
                S_OUTP: begin
                    if (i_adv) begin
                        r_state <= S_OUTM;
                    end
                end
                S_OUTM: begin
                    if (i_adv) begin
                        r_x     <= r_x - RAD_W'(1);
                        r_state <= S_INP;
                    end
                end
                S_INP: begin
                    if (i_adv) begin
                        r_state <= S_INM;
                    end
                end
                S_INM: begin
                    if (i_adv) begin
                        if (r_i == r_imax) begin
                            r_state <= S_DONE;
                        end else begin
                            r_i     <= r_i + RAD_W'(1);
                            r_state <= S_TEST;
                        end
                    end
                end
                S_DONE: begin
                    if (i_adv) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/fcsg_out.sv]
// Output stage of the span generator.
// Drops empty spans, holds one span back to mark the last word; uses fcsg_pkg.
module fcsg_out
    import fcsg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cand_valid,
    input  t_span              i_cand,
    input  logic               i_done,
    output logic               o_adv,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COORD_W-1:0] o_span_x_start,
    output logic [COORD_W-1:0] o_span_y,
    output logic [LEN_W-1:0]   o_span_length,
    output logic [COLOR_W-1:0] o_span_color,
    output logic               o_last_span
);

    logic  r_pend_valid;
    t_span r_pend;
    logic  r_out_valid;
    t_span r_out;
    logic  r_out_last;

    assign o_adv          = !r_out_valid || i_ready;
    assign o_valid        = r_out_valid;
    assign o_span_x_start = r_out.x_start;
    assign o_span_y       = r_out.y;
    assign o_span_length  = r_out.length;
    assign o_span_color   = r_out.color;
    assign o_last_span    = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_adv) begin
                if (i_done) begin
                    r_out        <= r_pend;
                    r_out_last   <= 1'b1;
                    r_out_valid  <= r_pend_valid;
                    r_pend_valid <= 1'b0;
                end else if (i_cand_valid && (i_cand.length != '0)) begin
                    if (r_pend_valid) begin
                        r_out       <= r_pend;
                        r_out_last  <= 1'b0;
                        r_out_valid <= 1'b1;
                    end
                    r_pend       <= i_cand;
                    r_pend_valid <= 1'b1;
                end
            end
        end
    end

endmodule
